[src/qse_pkg.sv]
// Shared types for the quicksort engine: sequencer states and the
// control bundles between the core and its range stack. No dependencies.
package qse_pkg;

  // Sequencer states of the core
  typedef enum logic [3:0] {
    S_LOAD,
    S_POP,
    S_RANGE,
    S_PIVOT,
    S_READ,
    S_CMP,
    S_SWAP,
    S_FIN_RD,
    S_FIN_HI,
    S_FIN_LO,
    S_PUSH_HI,
    S_PUSH_LO,
    S_EMIT_RD,
    S_EMIT
  } qse_state_e;

  // Requests from the core to the range stack
  typedef struct packed {
    logic push;
    logic pop;
  } qse_stack_req_t;

  // Status from the range stack
  typedef struct packed {
    logic empty;
    logic full;
  } qse_stack_rsp_t;

endpackage

[src/quicksort_engine_core.sv]
// Top level of the quicksort engine: element memory, sequencer and output
// register. Depends on qse_pkg and qse_range_stack.
//
// Values stream in one transfer per cycle into an element memory of DEPTH
// entries; values beyond DEPTH are taken and dropped. A transfer with last
// set closes the set: the block then stops taking input, sorts the stored
// values in ascending order by quicksort (Lomuto partition, pivot at the top
// of each range, ranges kept on an explicit stack) and streams them out,
// reading each value from memory and handing it to the output register
// once that is free, marking the final one with last_out. Partitioning runs
// through the element memory's single write port: each element is read and
// compared, one that moves to the low side takes a further swap step, and
// each range also takes a pop, a range latch, a pivot fetch, a final read,
// the writes that put the pivot in place and the pushes of its two parts.
// Input is taken again once the last value of the set has been handed to
// the output register. No clearing pass is needed after reset.
module quicksort_engine_core #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic                  last_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [VALUE_BITS-1:0] sorted_value_o,
  output logic                  last_out_o
);
  import qse_pkg::*;

  localparam int unsigned IDXW = $clog2(DEPTH);
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  // Sequencer and index registers
  qse_state_e        state_q, state_d;
  logic [CNTW-1:0]   count_q, count_d;
  logic [IDXW-1:0]   lo_q, lo_d, hi_q, hi_d, i_q, i_d, j_q, j_d, k_q, k_d;
  logic [VALUE_BITS-1:0] pivot_q, pivot_d;

  // Output register
  logic                  out_valid_q, out_valid_d;
  logic [VALUE_BITS-1:0] out_value_q, out_value_d;
  logic                  out_last_q, out_last_d;

  // Element memory ports
  logic [VALUE_BITS-1:0] elem_mem [DEPTH];
  logic                  rd_a_en, rd_b_en, mem_we;
  logic [IDXW-1:0]       rd_a_addr, rd_b_addr, mem_waddr;
  logic [VALUE_BITS-1:0] mem_wdata, rdata_a_q, rdata_b_q;

  // Range stack
  qse_stack_req_t  stk_req;
  qse_stack_rsp_t  stk_rsp;
  logic [IDXW-1:0] push_lo, push_hi, pop_lo, pop_hi;

  // Helpers
  logic            in_xfer, out_free, j_at_end, emit_last;
  logic [CNTW-1:0] n_total;

  assign in_stall_o = (state_q != S_LOAD);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign n_total    = (count_q < CNTW'(DEPTH)) ? count_q + 1'b1 : count_q;
  assign j_at_end   = (({1'b0, j_q} + 1'b1) == {1'b0, hi_q});
  assign emit_last  = ((CNTW'(k_q) + 1'b1) == count_q);

  qse_range_stack #(
    .DEPTH (DEPTH)
  ) u_stack (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (stk_req),
    .push_lo_i (push_lo),
    .push_hi_i (push_hi),
    .rsp_o     (stk_rsp),
    .pop_lo_o  (pop_lo),
    .pop_hi_o  (pop_hi)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_LOAD:    if (in_xfer && last_i) state_d = S_POP;
      S_POP:     state_d = stk_rsp.empty ? S_EMIT_RD : S_RANGE;
      S_RANGE:   state_d = (pop_lo >= pop_hi) ? S_POP : S_PIVOT;
      S_PIVOT:   state_d = S_READ;
      S_READ:    state_d = S_CMP;
      S_CMP: begin
        if (pivot_q > rdata_a_q) begin
          state_d = S_SWAP;
        end else begin
          state_d = j_at_end ? S_FIN_RD : S_READ;
        end
      end
      S_SWAP:    state_d = j_at_end ? S_FIN_RD : S_READ;
      S_FIN_RD:  state_d = S_FIN_HI;
      S_FIN_HI:  state_d = S_FIN_LO;
      S_FIN_LO:  state_d = S_PUSH_HI;
      S_PUSH_HI: state_d = S_PUSH_LO;
      S_PUSH_LO: state_d = S_POP;
      S_EMIT_RD: state_d = S_EMIT;
      S_EMIT: begin
        if (out_free) state_d = emit_last ? S_LOAD : S_EMIT_RD;
      end
      default:   state_d = S_LOAD;
    endcase
  end

  // Datapath control and memory ports
  always_comb begin
    count_d     = count_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    pivot_d     = pivot_q;
    rd_a_en     = 1'b0;
    rd_a_addr   = j_q;
    rd_b_en     = 1'b0;
    rd_b_addr   = i_q;
    mem_we      = 1'b0;
    mem_waddr   = i_q;
    mem_wdata   = rdata_a_q;
    stk_req     = '0;
    push_lo     = lo_q;
    push_hi     = hi_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_value_d = out_value_q;
    out_last_d  = out_last_q;
    case (state_q)
      S_LOAD: begin
        // Store the value unless the memory is full; seed the stack on last if two or more values are held
        if (in_xfer) begin
          count_d = n_total;
          if (count_q < CNTW'(DEPTH)) begin
            mem_we    = 1'b1;
            mem_waddr = count_q[IDXW-1:0];
            mem_wdata = value_i;
          end
          if (last_i && n_total >= CNTW'(2)) begin
            stk_req.push = 1'b1;
            push_lo      = '0;
            push_hi      = IDXW'(n_total - 1'b1);
          end
          k_d = '0;
        end
      end
      S_POP: begin
        stk_req.pop = 1'b1;
      end
      S_RANGE: begin
        // Latch the range and fetch its pivot
        lo_d      = pop_lo;
        hi_d      = pop_hi;
        i_d       = pop_lo;
        j_d       = pop_lo;
        rd_a_en   = 1'b1;
        rd_a_addr = pop_hi;
      end
      S_PIVOT: begin
        pivot_d = rdata_a_q;
      end
      S_READ: begin
        rd_a_en = 1'b1;
        rd_b_en = 1'b1;
      end
      S_CMP: begin
        // Smaller element: move it to slot i, old slot i goes next cycle
        if (pivot_q > rdata_a_q) begin
          mem_we    = 1'b1;
          mem_waddr = i_q;
          mem_wdata = rdata_a_q;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      S_SWAP: begin
        mem_we    = 1'b1;
        mem_waddr = j_q;
        mem_wdata = rdata_b_q;
        i_d       = i_q + 1'b1;
        j_d       = j_q + 1'b1;
      end
      S_FIN_RD: begin
        rd_b_en = 1'b1;
      end
      S_FIN_HI: begin
        mem_we    = 1'b1;
        mem_waddr = hi_q;
        mem_wdata = rdata_b_q;
      end
      S_FIN_LO: begin
        mem_we    = 1'b1;
        mem_waddr = i_q;
        mem_wdata = pivot_q;
      end
      S_PUSH_HI: begin
        if (({1'b0, i_q} + 1'b1) < {1'b0, hi_q}) begin
          stk_req.push = 1'b1;
          push_lo      = i_q + 1'b1;
          push_hi      = hi_q;
        end
      end
      S_PUSH_LO: begin
        if ({1'b0, i_q} > ({1'b0, lo_q} + 1'b1)) begin
          stk_req.push = 1'b1;
          push_lo      = lo_q;
          push_hi      = i_q - 1'b1;
        end
      end
      S_EMIT_RD: begin
        rd_a_en   = 1'b1;
        rd_a_addr = k_q;
      end
      S_EMIT: begin
        // Hand the value over once the output register frees up
        if (out_free) begin
          out_valid_d = 1'b1;
          out_value_d = rdata_a_q;
          out_last_d  = emit_last;
          k_d         = k_q + 1'b1;
          if (emit_last) count_d = '0;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    i_q         <= i_d;
    j_q         <= j_d;
    k_q         <= k_d;
    pivot_q     <= pivot_d;
    out_value_q <= out_value_d;
    out_last_q  <= out_last_d;
  end

  // Element memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      elem_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_a_en) begin
      rdata_a_q <= elem_mem[rd_a_addr];
    end
    if (rd_b_en) begin
      rdata_b_q <= elem_mem[rd_b_addr];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sorted_value_o = out_value_q;
  assign last_out_o     = out_last_q;

  // Partition indices stay ordered inside the current range
  a_part_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP || state_q == S_SWAP) |-> (i_q <= j_q && j_q < hi_q))
    else $error("partition indices out of order");

  // The range stack is never pushed while full
  a_stack_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stk_req.push |-> !stk_rsp.full)
    else $error("range stack overflow");

  // Emission only happens with a nonempty set
  a_emit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT_RD) |-> (count_q != '0 && CNTW'(k_q) < count_q))
    else $error("emission beyond stored set");

  // A set closes with a marked value before input is taken again
  a_emit_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && state_d == S_LOAD) |=> (out_valid_q && out_last_q))
    else $error("set closed without final mark");

endmodule

[src/qse_range_stack.sv]
// Range stack of the quicksort engine: a synchronous memory of (low, high)
// index pairs with its top pointer. Depends on qse_pkg.
module qse_range_stack #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  qse_pkg::qse_stack_req_t      req_i,
  input  logic [$clog2(DEPTH)-1:0]     push_lo_i,
  input  logic [$clog2(DEPTH)-1:0]     push_hi_i,
  output qse_pkg::qse_stack_rsp_t      rsp_o,
  output logic [$clog2(DEPTH)-1:0]     pop_lo_o,
  output logic [$clog2(DEPTH)-1:0]     pop_hi_o
);
  import qse_pkg::*;

  localparam int unsigned IDXW = $clog2(DEPTH);
  localparam int unsigned TOPW = $clog2(DEPTH + 1);

  logic [2*IDXW-1:0] stack_mem [DEPTH];
  logic [2*IDXW-1:0] rd_q;
  logic [TOPW-1:0]   top_q, top_d, top_dec;
  logic              do_push, do_pop;

  // Status and guarded operations
  assign rsp_o.full  = (top_q == TOPW'(DEPTH));
  assign rsp_o.empty = (top_q == '0);
  assign do_push     = req_i.push && !rsp_o.full;
  assign do_pop      = req_i.pop && !rsp_o.empty;
  assign top_dec     = top_q - 1'b1;

  // Advance the top pointer
  always_comb begin
    top_d = top_q;
    if (do_push) begin
      top_d = top_q + 1'b1;
    end else if (do_pop) begin
      top_d = top_dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= '0;
    end else begin
      top_q <= top_d;
    end
  end

  // Write on push, registered read on pop
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      stack_mem[top_q[IDXW-1:0]] <= {push_lo_i, push_hi_i};
    end
    if (do_pop) begin
      rd_q <= stack_mem[top_dec[IDXW-1:0]];
    end
  end

  assign pop_lo_o = rd_q[2*IDXW-1:IDXW];
  assign pop_hi_o = rd_q[IDXW-1:0];

endmodule

[dv/quicksort_engine_core_scoreboard.sv]
// Scoreboard for quicksort_engine_core: watches the value and result channels,
// keeps its own copy of the loaded set, orders it and checks each result.
// Stand-alone, no package needed.
module quicksort_engine_core_scoreboard #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic                  last_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [VALUE_BITS-1:0] sorted_value_i,
  input  logic                  last_out_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o
);

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  last;
  } sorted_item_t;

  logic [VALUE_BITS-1:0] held_vals [DEPTH];
  int unsigned           held_count = 0;
  sorted_item_t          due_q [$];
  sorted_item_t          want;

  // Print one line per mismatch and count it
  task automatic report_mismatch(input string what);
    $display("error @%0t: %s", $time, what);
    fail_count_o++;
  endtask

  // Quicksort of the held set: Lomuto split around the top element of each
  // range, ranges kept on an explicit stack of {low, high} index pairs
  function automatic void order_set();
    logic [11:0]           ranges [DEPTH];
    int unsigned           depth_used;
    int unsigned           lo, hi, i, j;
    logic [VALUE_BITS-1:0] pivot, tmp;
    depth_used = 0;
    if (held_count < 2) return;
    ranges[0] = {6'd0, 6'(held_count - 1)};
    depth_used = 1;
    while (depth_used > 0) begin
      depth_used--;
      lo = ranges[depth_used][11:6];
      hi = ranges[depth_used][5:0];
      if (lo < hi) begin
        pivot = held_vals[hi];
        i = lo;
        // move strictly smaller values below the split point
        for (j = lo; j < hi; j++) begin
          if (held_vals[j] < pivot) begin
            tmp = held_vals[i];
            held_vals[i] = held_vals[j];
            held_vals[j] = tmp;
            i++;
          end
        end
        tmp = held_vals[i];
        held_vals[i] = held_vals[hi];
        held_vals[hi] = tmp;
        if (i + 1 < hi && depth_used < DEPTH) begin
          ranges[depth_used] = {6'(i + 1), 6'(hi)};
          depth_used++;
        end
        if (i > lo + 1 && depth_used < DEPTH) begin
          ranges[depth_used] = {6'(lo), 6'(i - 1)};
          depth_used++;
        end
      end
    end
  endfunction

  // Check result transfers first, then take in value transfers
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_count   = 0;
      fail_count_o = 0;
      pending_o    = 0;
      due_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (due_q.size() == 0) begin
          report_mismatch($sformatf("result %h with nothing due", sorted_value_i));
        end else begin
          want = due_q.pop_front();
          if (sorted_value_i !== want.value)
            report_mismatch($sformatf("sorted_value %h, want %h", sorted_value_i, want.value));
          if (last_out_i !== want.last)
            report_mismatch($sformatf("last_out %b, want %b", last_out_i, want.last));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        // drop values beyond the store depth, the closing one included
        if (held_count < DEPTH) begin
          held_vals[held_count] = value_i;
          held_count++;
        end
        if (last_i) begin
          order_set();
          for (int unsigned k = 0; k < held_count; k++) begin
            want.value = held_vals[k];
            want.last  = (k + 1 == held_count);
            due_q.push_back(want);
          end
          held_count = 0;
        end
      end
      pending_o = due_q.size();
    end
  end

endmodule

[dv/quicksort_engine_core_test.sv]
// Testbench top for quicksort_engine_core: clock, reset, value stimulus and
// result backpressure. Depends on quicksort_engine_core_scoreboard.
module quicksort_engine_core_test;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned VALUE_BITS = 16;

  typedef enum int unsigned {
    FILL_RANDOM,
    FILL_FEW,
    FILL_RISING,
    FILL_FALLING
  } fill_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [VALUE_BITS-1:0] value_i;
  logic                  last_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [VALUE_BITS-1:0] sorted_value_o;
  logic                  last_out_o;

  int unsigned fail_count;
  int unsigned pending;
  logic        calm = 1'b0;
  logic        hold_go = 1'b0;
  logic        hold_long = 1'b0;
  int unsigned stall_left = 0;

  always #5 clk_i = ~clk_i;

  quicksort_engine_core #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .value_i        (value_i),
    .last_i         (last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sorted_value_o (sorted_value_o),
    .last_out_o     (last_out_o)
  );

  quicksort_engine_core_scoreboard #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) scoreboard (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .value_i        (value_i),
    .last_i         (last_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sorted_value_i (sorted_value_o),
    .last_out_i     (last_out_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // Stall results in random bursts; no new burst starts during the calm tail
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 17);
    end
  end

  assign out_stall_i = hold_long | (stall_left != 0);

  // Hold off the result side for a long stretch so the input backs up
  initial begin : long_hold
    wait (hold_go);
    @(negedge clk_i);
    hold_long <= 1'b1;
    repeat (400) @(negedge clk_i);
    hold_long <= 1'b0;
  end

  // Offer one value after an optional gap; return at the negedge after the transfer
  task automatic push_value(input logic [VALUE_BITS-1:0] v, input logic l);
    int unsigned gap;
    gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 17) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    last_i     <= l;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  function automatic logic [VALUE_BITS-1:0] make_value(input fill_e fill, input int unsigned k);
    logic [VALUE_BITS-1:0] v;
    case (fill)
      FILL_FEW:     v = VALUE_BITS'($urandom_range(0, 3)) * 16'h5555;
      FILL_RISING:  v = VALUE_BITS'(k * 900 + $urandom_range(0, 899));
      FILL_FALLING: v = 16'hFFFF - VALUE_BITS'(k * 900 + $urandom_range(0, 899));
      default:      v = VALUE_BITS'($urandom());
    endcase
    return v;
  endfunction

  initial begin : stimulus
    int unsigned sent;
    int unsigned set_no;
    int unsigned size;
    fill_e       fill;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    value_i    = '0;
    last_i     = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Single-value set
    push_value(16'hBEEF, 1'b1);
    // Extremes, reversed and already in order
    push_value(16'hFFFF, 1'b0);
    push_value(16'h0000, 1'b1);
    push_value(16'h0000, 1'b0);
    push_value(16'hFFFF, 1'b1);
    // Equal values
    push_value(16'h0005, 1'b0);
    push_value(16'h0005, 1'b0);
    push_value(16'h0005, 1'b1);
    // Strictly falling
    push_value(16'hFFFF, 1'b0);
    push_value(16'h8000, 1'b0);
    push_value(16'h00FF, 1'b0);
    push_value(16'h0001, 1'b0);
    push_value(16'h0000, 1'b1);
    // Alternating bit patterns, single set bits and extremes
    push_value(16'hAAAA, 1'b0);
    push_value(16'h5555, 1'b0);
    push_value(16'h8000, 1'b0);
    push_value(16'h0001, 1'b0);
    push_value(16'hFFFF, 1'b0);
    push_value(16'h0000, 1'b1);

    // Random sets: mostly small, a few full and overflowing ones
    hold_go = 1'b1;
    sent    = 0;
    set_no  = 0;
    while (sent < 260) begin
      if (set_no == 2)
        size = DEPTH + 2;
      else if (set_no == 5)
        size = DEPTH;
      else if ($urandom_range(0, 11) == 0)
        size = $urandom_range(DEPTH, DEPTH + 6);
      else
        size = $urandom_range(1, 12);
      fill = (set_no == 2) ? FILL_RISING : fill_e'($urandom_range(0, 3));
      if (sent >= 220) calm <= 1'b1;
      for (int unsigned k = 0; k < size; k++) begin
        push_value(make_value(fill, k), k + 1 == size);
      end
      sent += size;
      set_no++;
    end
    in_valid_i <= 1'b0;

    // Drain, then allow time for any stray result
    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // End a hung run
  initial begin : watchdog
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[sim.f]
src/qse_pkg.sv
src/qse_range_stack.sv
src/quicksort_engine_core.sv
dv/quicksort_engine_core_scoreboard.sv
dv/quicksort_engine_core_test.sv
